/* src/qfgf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfgf_pkg
// Types, widths and constants shared by the quad face geometric factor block.
// ----------------------------------------------------------------------------
package qfgf_pkg;

  localparam int COORD_W  = 32;
  localparam int WEIGHT_W = 31;
  localparam int ROOT_W   = 33;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int QUO_W    = 32;
  localparam int AJ_W     = 64;
  localparam int PROD_W   = 95;
  localparam int ADDR_W   = 3;

  localparam logic [ADDR_W-3:0]   REG_CORNER_WEIGHT   = 1'b0;
  localparam logic [WEIGHT_W-1:0] CORNER_WEIGHT_RESET = 31'd1073741824;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAG = 32'h8000_0000;

  localparam int DEG_EDGE = 0;
  localparam int DEG_JAC  = 1;

  typedef struct packed {
    logic signed [31:0] vx0;
    logic signed [31:0] vx1;
    logic signed [31:0] vx2;
    logic signed [31:0] vx3;
    logic signed [31:0] vy0;
    logic signed [31:0] vy1;
    logic signed [31:0] vy2;
    logic signed [31:0] vy3;
    logic [1:0]         face_index;
    logic signed [31:0] ref_r;
    logic signed [31:0] ref_s;
    logic [30:0]        node_weight;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] surface_jac;
    logic signed [31:0] inv_vol_jac;
    logic signed [31:0] weighted_inv_jac;
    logic signed [31:0] weighted_surf_jac;
    logic [1:0]         degenerate;
  } out_word_t;

  typedef struct packed {
    logic [31:0]         abs_nx;
    logic [31:0]         abs_ny;
    logic                sign_nx;
    logic                sign_ny;
    logic [WEIGHT_W-1:0] w;
    logic                neg;
    logic                jz;
    logic                ij_sat;
    logic [AJ_W-1:0]     aj;
    logic                wij_sat;
    logic [PROD_W-1:0]   p;
  } geo_t;

endpackage

/* src/qfgf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfgf_front
// Eight-stage front end: bilinear Jacobian entries, determinant, scaled
// determinant and the squared edge length.
// ----------------------------------------------------------------------------
module qfgf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  qfgf_pkg::in_word_t   in_data,
  input  logic [30:0]          corner_weight,
  output logic                 out_vld,
  output logic [64:0]          out_rad,
  output qfgf_pkg::geo_t       out_geo
);

  typedef struct packed {
    logic [31:0] abs_nx;
    logic [31:0] abs_ny;
    logic        sign_nx;
    logic        sign_ny;
    logic [30:0] w;
  } edge_t;

  logic [7:0] vld_r;

  logic signed [33:0] a1 [4];
  logic signed [33:0] b1 [4];
  logic signed [31:0] t1 [4];
  logic signed [31:0] xf, xg, yf, yg;
  logic signed [32:0] ex, ey;
  edge_t              edge1_nxt;

  logic signed [33:0] sum1_r [4];
  logic signed [33:0] dif1_r [4];
  logic signed [31:0] t1_r   [4];
  edge_t              edge1_r;

  logic signed [33:0] sum2_r [4];
  logic signed [65:0] pm2_r  [4];
  logic [63:0]        sqx2_r, sqy2_r;
  edge_t              edge2_r;

  logic signed [31:0] ent3_nxt [4];
  logic signed [31:0] ent3_r   [4];
  logic [64:0]        rad3_r;
  edge_t              edge3_r;

  logic signed [63:0] p4a_r, p4b_r;
  logic [64:0]        rad4_r;
  edge_t              edge4_r;

  logic signed [64:0] jac5_r;
  logic [64:0]        rad5_r;
  edge_t              edge5_r;

  logic [63:0]        aj6_r;
  logic               neg6_r, jz6_r;
  logic [64:0]        rad6_r;
  edge_t              edge6_r;

  logic [62:0]        lo7_r, hi7_r;
  logic [63:0]        aj7_r;
  logic               neg7_r, jz7_r, ij_sat7_r;
  logic [64:0]        rad7_r;
  edge_t              edge7_r;

  qfgf_pkg::geo_t     geo8_nxt, geo8_r;
  logic [94:0]        p8;
  logic [64:0]        rad8_r;

  always_comb begin
    a1[0] = 34'(in_data.vx1) - 34'(in_data.vx0);
    b1[0] = 34'(in_data.vx2) - 34'(in_data.vx3);
    t1[0] = in_data.ref_s;
    a1[1] = 34'(in_data.vx3) - 34'(in_data.vx0);
    b1[1] = 34'(in_data.vx2) - 34'(in_data.vx1);
    t1[1] = in_data.ref_r;
    a1[2] = 34'(in_data.vy1) - 34'(in_data.vy0);
    b1[2] = 34'(in_data.vy2) - 34'(in_data.vy3);
    t1[2] = in_data.ref_s;
    a1[3] = 34'(in_data.vy3) - 34'(in_data.vy0);
    b1[3] = 34'(in_data.vy2) - 34'(in_data.vy1);
    t1[3] = in_data.ref_r;
  end

  always_comb begin
    case (in_data.face_index)
      2'd0: begin
        xf = in_data.vx0; xg = in_data.vx1; yf = in_data.vy0; yg = in_data.vy1;
      end
      2'd1: begin
        xf = in_data.vx1; xg = in_data.vx2; yf = in_data.vy1; yg = in_data.vy2;
      end
      2'd2: begin
        xf = in_data.vx2; xg = in_data.vx3; yf = in_data.vy2; yg = in_data.vy3;
      end
      default: begin
        xf = in_data.vx3; xg = in_data.vx0; yf = in_data.vy3; yg = in_data.vy0;
      end
    endcase
    ex = 33'(xg) - 33'(xf);
    ey = 33'(yg) - 33'(yf);
    edge1_nxt.sign_nx = ey[32];
    edge1_nxt.abs_nx  = ey[32] ? 32'(-ey) : ey[31:0];
    edge1_nxt.sign_ny = ~ex[32] && (ex != 33'sd0);
    edge1_nxt.abs_ny  = ex[32] ? 32'(-ex) : ex[31:0];
    edge1_nxt.w       = in_data.node_weight;
  end

  always_comb begin
    logic signed [66:0] acc;
    logic signed [34:0] ent;
    for (int i = 0; i < 4; i++) begin
      acc = (67'(sum2_r[i]) <<< 30) + 67'(pm2_r[i]);
      ent = $signed(acc[66:32]);
      if (ent > 35'sd2147483647) begin
        ent3_nxt[i] = 32'sh7FFF_FFFF;
      end else if (ent < -35'sd2147483647) begin
        ent3_nxt[i] = 32'sh8000_0001;
      end else begin
        ent3_nxt[i] = ent[31:0];
      end
    end
  end

  always_comb begin
    p8 = (95'(hi7_r) << 32) + 95'(lo7_r);
    geo8_nxt.abs_nx  = edge7_r.abs_nx;
    geo8_nxt.abs_ny  = edge7_r.abs_ny;
    geo8_nxt.sign_nx = edge7_r.sign_nx;
    geo8_nxt.sign_ny = edge7_r.sign_ny;
    geo8_nxt.w       = edge7_r.w;
    geo8_nxt.neg     = neg7_r;
    geo8_nxt.jz      = jz7_r;
    geo8_nxt.ij_sat  = ij_sat7_r;
    geo8_nxt.aj      = aj7_r;
    geo8_nxt.wij_sat = (p8 <= 95'd70368744177664);
    geo8_nxt.p       = p8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[6:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sum1_r[i] <= a1[i] + b1[i];
      dif1_r[i] <= b1[i] - a1[i];
      t1_r[i]   <= t1[i];
      sum2_r[i] <= sum1_r[i];
      pm2_r[i]  <= 66'(t1_r[i]) * 66'(dif1_r[i]);
      ent3_r[i] <= ent3_nxt[i];
    end
    edge1_r   <= edge1_nxt;
    sqx2_r    <= 64'(edge1_r.abs_nx) * 64'(edge1_r.abs_nx);
    sqy2_r    <= 64'(edge1_r.abs_ny) * 64'(edge1_r.abs_ny);
    edge2_r   <= edge1_r;
    rad3_r    <= 65'(sqx2_r) + 65'(sqy2_r);
    edge3_r   <= edge2_r;
    p4a_r     <= 64'(ent3_r[0]) * 64'(ent3_r[3]);
    p4b_r     <= 64'(ent3_r[1]) * 64'(ent3_r[2]);
    rad4_r    <= rad3_r;
    edge4_r   <= edge3_r;
    jac5_r    <= 65'(p4a_r) - 65'(p4b_r);
    rad5_r    <= rad4_r;
    edge5_r   <= edge4_r;
    neg6_r    <= jac5_r[64];
    jz6_r     <= (jac5_r == 65'sd0);
    aj6_r     <= jac5_r[64] ? 64'(-jac5_r) : jac5_r[63:0];
    rad6_r    <= rad5_r;
    edge6_r   <= edge5_r;
    lo7_r     <= 63'(aj6_r[31:0]) * 63'(corner_weight);
    hi7_r     <= 63'(aj6_r[63:32]) * 63'(corner_weight);
    aj7_r     <= aj6_r;
    neg7_r    <= neg6_r;
    jz7_r     <= jz6_r;
    ij_sat7_r <= (aj6_r <= 64'd65536);
    rad7_r    <= rad6_r;
    edge7_r   <= edge6_r;
    geo8_r    <= geo8_nxt;
    rad8_r    <= rad7_r;
  end

  assign out_vld = vld_r[7];
  assign out_rad = rad8_r;
  assign out_geo = geo8_r;

endmodule

/* src/qfgf_sqrt_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfgf_sqrt_pipe
// Integer square root, one root bit per pipeline stage, with a side word
// carried alongside.
// ----------------------------------------------------------------------------
module qfgf_sqrt_pipe #(
  parameter int ROOT_W = qfgf_pkg::ROOT_W,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] vld_r;
  logic [REM_W-1:0]  rem_r   [ROOT_W];
  logic [REM_W-1:0]  rem_nxt [ROOT_W];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [RAD_W-1:0]  rad_r   [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt [ROOT_W];
  logic [SIDE_W-1:0] side_r   [ROOT_W];
  logic [SIDE_W-1:0] side_nxt [ROOT_W];

  always_comb begin
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rem_i       = '0;
        root_i      = '0;
        rad_i       = in_rad;
        side_nxt[k] = in_side;
      end else begin
        rem_i       = rem_r[k-1];
        root_i      = root_r[k-1];
        rad_i       = rad_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      cur   = {rem_i, rad_i[RAD_W-1-2*k -: 2]};
      trial = {REM_W'(root_i), 2'b01};
      if (cur >= trial) begin
        rem_nxt[k]  = REM_W'(cur - trial);
        root_nxt[k] = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = REM_W'(cur);
        root_nxt[k] = {root_i[ROOT_W-2:0], 1'b0};
      end
      rad_nxt[k] = rad_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ROOT_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      rad_r[k]  <= rad_nxt[k];
      side_r[k] <= side_nxt[k];
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

/* src/qfgf_div_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfgf_div_pipe
// Restoring divider, one quotient bit per pipeline stage, with a side word
// carried alongside.
// ----------------------------------------------------------------------------
module qfgf_div_pipe #(
  parameter int DEN_W  = qfgf_pkg::ROOT_W,
  parameter int QUO_W  = qfgf_pkg::QUO_W,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [DEN_W-1:0]   in_rem,
  input  logic [QUO_W-1:0]   in_num,
  input  logic [DEN_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_vld,
  output logic [QUO_W-1:0]   out_quo,
  output logic [SIDE_W-1:0]  out_side
);

  logic [QUO_W-1:0]  vld_r;
  logic [DEN_W-1:0]  rem_r   [QUO_W];
  logic [DEN_W-1:0]  rem_nxt [QUO_W];
  logic [DEN_W-1:0]  den_r   [QUO_W];
  logic [DEN_W-1:0]  den_nxt [QUO_W];
  logic [QUO_W-1:0]  num_r   [QUO_W];
  logic [QUO_W-1:0]  num_nxt [QUO_W];
  logic [QUO_W-1:0]  quo_r   [QUO_W];
  logic [QUO_W-1:0]  quo_nxt [QUO_W];
  logic [SIDE_W-1:0] side_r   [QUO_W];
  logic [SIDE_W-1:0] side_nxt [QUO_W];

  always_comb begin
    logic [DEN_W-1:0] rem_i;
    logic [DEN_W-1:0] den_i;
    logic [QUO_W-1:0] num_i;
    logic [QUO_W-1:0] quo_i;
    logic [DEN_W:0]   cur;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        rem_i       = in_rem;
        den_i       = in_den;
        num_i       = in_num;
        quo_i       = '0;
        side_nxt[k] = in_side;
      end else begin
        rem_i       = rem_r[k-1];
        den_i       = den_r[k-1];
        num_i       = num_r[k-1];
        quo_i       = quo_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      cur = {rem_i, num_i[QUO_W-1-k]};
      if (cur >= {1'b0, den_i}) begin
        rem_nxt[k] = DEN_W'(cur - {1'b0, den_i});
        quo_nxt[k] = {quo_i[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = DEN_W'(cur);
        quo_nxt[k] = {quo_i[QUO_W-2:0], 1'b0};
      end
      den_nxt[k] = den_i;
      num_nxt[k] = num_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QUO_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      rem_r[k]  <= rem_nxt[k];
      den_r[k]  <= den_nxt[k];
      num_r[k]  <= num_nxt[k];
      quo_r[k]  <= quo_nxt[k];
      side_r[k] <= side_nxt[k];
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = quo_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];

endmodule

/* src/quad_face_geometric_factors.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_face_geometric_factors
// Face geometric factors of a bilinear four-vertex element: unit normal,
// surface Jacobian, reciprocal volume Jacobian and their weighted forms.
//
//   Channel   Ports                                   Moves
//   input     start, busy, in_data                    one in_word_t word
//   result    out_strobe, out_data                    one out_word_t word
//   config    psel, penable, pwrite, paddr, pwdata,   corner_weight
//             prdata, pready
//
// A word is taken in every cycle; its result passes through the eight front
// stages, the 33-stage square root, one product stage, the 32-stage dividers
// and the output register. Reset clears all valid bits and sets corner_weight
// to one. busy stays low and nothing stalls.
// ----------------------------------------------------------------------------
module quad_face_geometric_factors (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  qfgf_pkg::in_word_t               in_data,
  output logic                             out_strobe,
  output qfgf_pkg::out_word_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qfgf_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  typedef struct packed {
    logic        neg;
    logic        jz;
    logic        wij_sat;
    logic        d_zero;
    logic [31:0] sj;
    logic [31:0] wsj;
  } misc_side_t;

  localparam int GEO_W  = $bits(qfgf_pkg::geo_t);
  localparam int MISC_W = $bits(misc_side_t);

  logic [qfgf_pkg::WEIGHT_W-1:0] corner_weight_r;

  logic                 fr_vld;
  logic [64:0]          fr_rad;
  qfgf_pkg::geo_t       fr_geo;

  logic                 sq_vld;
  logic [qfgf_pkg::ROOT_W-1:0] sq_root;
  logic [GEO_W-1:0]     sq_side;
  qfgf_pkg::geo_t       sq_geo;

  logic                 p1_vld_r;
  logic [qfgf_pkg::ROOT_W-1:0] p1_d_r;
  logic [63:0]          p1_dw_r;
  qfgf_pkg::geo_t       p1_geo_r;
  misc_side_t           p1_misc;

  logic                 dv_vld;
  logic [31:0]          nx_quo, ny_quo, ij_quo, wij_quo;
  logic                 nx_sign, ny_sign, ij_sat;
  logic [MISC_W-1:0]    wij_side;
  misc_side_t           dv_misc;

  qfgf_pkg::out_word_t  out_nxt, out_r;
  logic                 out_vld_r;

  function automatic logic [31:0] sat_mag(input logic [31:0] mag, input logic neg);
    logic [31:0] m;
    if (neg) begin
      m = (mag > qfgf_pkg::NEG_MAG) ? qfgf_pkg::NEG_MAG : mag;
      return -m;
    end else begin
      return (mag > qfgf_pkg::POS_MAX) ? qfgf_pkg::POS_MAX : mag;
    end
  endfunction

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[qfgf_pkg::ADDR_W-1:2] == qfgf_pkg::REG_CORNER_WEIGHT) ?
                  {1'b0, corner_weight_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_weight_r <= qfgf_pkg::CORNER_WEIGHT_RESET;
    end else if (psel && penable && pwrite &&
                 (paddr[qfgf_pkg::ADDR_W-1:2] == qfgf_pkg::REG_CORNER_WEIGHT)) begin
      corner_weight_r <= pwdata[qfgf_pkg::WEIGHT_W-1:0];
    end
  end

  qfgf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (start && !busy),
    .in_data       (in_data),
    .corner_weight (corner_weight_r),
    .out_vld       (fr_vld),
    .out_rad       (fr_rad),
    .out_geo       (fr_geo)
  );

  qfgf_sqrt_pipe #(
    .ROOT_W (qfgf_pkg::ROOT_W),
    .SIDE_W (GEO_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_rad   ({1'b0, fr_rad}),
    .in_side  (fr_geo),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  assign sq_geo = sq_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_d_r   <= sq_root;
    p1_dw_r  <= 64'(sq_root) * 64'(sq_geo.w);
    p1_geo_r <= sq_geo;
  end

  always_comb begin
    p1_misc.neg     = p1_geo_r.neg;
    p1_misc.jz      = p1_geo_r.jz;
    p1_misc.wij_sat = p1_geo_r.wij_sat;
    p1_misc.d_zero  = (p1_d_r == '0);
    p1_misc.sj      = p1_d_r[32] ? qfgf_pkg::POS_MAX : {1'b0, p1_d_r[31:1]};
    p1_misc.wsj     = (p1_dw_r[63] || p1_dw_r[62]) ? qfgf_pkg::POS_MAX :
                      {1'b0, p1_dw_r[61:31]};
  end

  qfgf_div_pipe #(
    .DEN_W  (qfgf_pkg::ROOT_W),
    .QUO_W  (qfgf_pkg::QUO_W),
    .SIDE_W (1)
  ) u_div_nx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p1_vld_r),
    .in_rem   (qfgf_pkg::ROOT_W'(p1_geo_r.abs_nx[31:16])),
    .in_num   ({p1_geo_r.abs_nx[15:0], 16'd0}),
    .in_den   (p1_d_r),
    .in_side  (p1_geo_r.sign_nx),
    .out_vld  (),
    .out_quo  (nx_quo),
    .out_side (nx_sign)
  );

  qfgf_div_pipe #(
    .DEN_W  (qfgf_pkg::ROOT_W),
    .QUO_W  (qfgf_pkg::QUO_W),
    .SIDE_W (1)
  ) u_div_ny (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p1_vld_r),
    .in_rem   (qfgf_pkg::ROOT_W'(p1_geo_r.abs_ny[31:16])),
    .in_num   ({p1_geo_r.abs_ny[15:0], 16'd0}),
    .in_den   (p1_d_r),
    .in_side  (p1_geo_r.sign_ny),
    .out_vld  (),
    .out_quo  (ny_quo),
    .out_side (ny_sign)
  );

  qfgf_div_pipe #(
    .DEN_W  (qfgf_pkg::AJ_W),
    .QUO_W  (qfgf_pkg::QUO_W),
    .SIDE_W (1)
  ) u_div_ij (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p1_vld_r),
    .in_rem   (64'd65536),
    .in_num   (32'd0),
    .in_den   (p1_geo_r.aj),
    .in_side  (p1_geo_r.ij_sat),
    .out_vld  (),
    .out_quo  (ij_quo),
    .out_side (ij_sat)
  );

  qfgf_div_pipe #(
    .DEN_W  (qfgf_pkg::PROD_W),
    .QUO_W  (qfgf_pkg::QUO_W),
    .SIDE_W (MISC_W)
  ) u_div_wij (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p1_vld_r),
    .in_rem   (95'd70368744177664),
    .in_num   (32'd0),
    .in_den   (p1_geo_r.p),
    .in_side  (p1_misc),
    .out_vld  (dv_vld),
    .out_quo  (wij_quo),
    .out_side (wij_side)
  );

  assign dv_misc = wij_side;

  always_comb begin
    out_nxt = '0;
    if (!dv_misc.d_zero) begin
      out_nxt.normal_x          = nx_sign ? -nx_quo : nx_quo;
      out_nxt.normal_y          = ny_sign ? -ny_quo : ny_quo;
      out_nxt.surface_jac       = dv_misc.sj;
      out_nxt.weighted_surf_jac = dv_misc.wsj;
    end
    if (!dv_misc.jz) begin
      out_nxt.inv_vol_jac      = sat_mag(ij_sat ? 32'hFFFF_FFFF : ij_quo, dv_misc.neg);
      out_nxt.weighted_inv_jac = sat_mag(dv_misc.wij_sat ? 32'hFFFF_FFFF : wij_quo,
                                         dv_misc.neg);
    end
    out_nxt.degenerate[qfgf_pkg::DEG_EDGE] = dv_misc.d_zero;
    out_nxt.degenerate[qfgf_pkg::DEG_JAC]  = dv_misc.jz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule
